// File: src/aeg_pkg.sv
// shared types and constants for the adsr envelope generator
// no dependencies; imported by every module of the block
`default_nettype none

package aeg_pkg;

  // point table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  // the table pointer can also sit one past the last entry
  localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);

  localparam int LEVEL_W = 16;
  localparam int ACC_W   = 32;
  localparam int CFG_W   = 16;

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_INITIAL = 2'd0;
  localparam logic [1:0] REG_SUSTAIN = 2'd1;
  localparam logic [1:0] REG_RELEASE = 2'd2;
  localparam logic [1:0] REG_HANG    = 2'd3;

  // envelope phases
  localparam logic [3:0] PH_OFF     = 4'd0;
  localparam logic [3:0] PH_START   = 4'd1;
  localparam logic [3:0] PH_LOOP    = 4'd2;
  localparam logic [3:0] PH_FETCH   = 4'd3;
  localparam logic [3:0] PH_RAMP    = 4'd4;
  localparam logic [3:0] PH_HANG    = 4'd5;
  localparam logic [3:0] PH_DECAY   = 4'd6;
  localparam logic [3:0] PH_RELEASE = 4'd7;
  localparam logic [3:0] PH_SUSTAIN = 4'd8;

  // marker codes held in the delay half of a table entry
  localparam logic signed [15:0] DLY_END     = 16'sd0;
  localparam logic signed [15:0] DLY_HANG    = -16'sd1;
  localparam logic signed [15:0] DLY_JUMP    = -16'sd2;
  localparam logic signed [15:0] DLY_RESTART = -16'sd3;

  typedef struct packed {
    logic signed [15:0] delay;
    logic signed [15:0] value;
  } entry_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [4:0]         entry_index;
    logic signed [15:0] entry_delay;
    logic signed [15:0] entry_value;
    logic               decay_request;
    logic               release_request;
  } aeg_in_t;

  typedef struct packed {
    logic signed [15:0] level;
    logic [3:0]         phase;
  } aeg_out_t;

endpackage

`default_nettype wire

// File: src/aeg_table.sv
// point table store: one write port, one registered read port
// depends on aeg_pkg; pointers past the last entry read as the end marker
`default_nettype none

module aeg_table
  import aeg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_entry,
  input  wire logic             rd_en,
  input  wire logic [PTR_W-1:0] rd_ptr,
  output entry_t                rd_entry
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q_r;
  logic   rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q_r   <= mem[rd_ptr[IDX_W-1:0]];
      rd_hit_r <= (rd_ptr < PTR_W'(TABLE_DEPTH));
    end
  end

  assign rd_entry = rd_hit_r ? rd_q_r : '0;

endmodule

`default_nettype wire

// File: src/aeg_divider.sv
// serial signed divider, 32-bit dividend by 16-bit divisor, truncating
// one quotient bit per cycle; depends on aeg_pkg
`default_nettype none

module aeg_divider
  import aeg_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [ACC_W-1:0] dividend,
  input  wire logic signed [15:0]      divisor,
  output logic                         done,
  output logic [ACC_W-1:0]             quotient
);

  localparam int CNT_W = $clog2(ACC_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0] dvd_r, dvd_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [15:0]      den_r, den_nxt;
  logic             neg_r, neg_nxt;

  logic [16:0]      rem_sh;
  logic             fits;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[ACC_W-1]};
    fits     = (rem_sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      // magnitudes; the most negative values map to their unsigned size
      dvd_nxt  = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
      den_nxt  = divisor[15] ? 16'(-divisor) : 16'(divisor);
      neg_nxt  = dividend[ACC_W-1] ^ divisor[15];
    end else if (busy_r) begin
      rem_nxt = fits ? 16'(rem_sh - {1'b0, den_r}) : rem_sh[15:0];
      dvd_nxt = {dvd_r[ACC_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(ACC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -dvd_r : dvd_r;

endmodule

`default_nettype wire

// File: src/adsr_envelope_generator.sv
// Envelope generator for one voice. Write items load (delay, target) points
// into a 32-entry table, a start item arms the envelope, and each tick item
// advances it one step: a linear 16.16 ramp toward the current point, a table
// marker (end, hang, jump, restart), or one decay, sustain or release step.
// Every accepted transaction returns exactly one result with the level and
// phase after it. One transaction is in flight at a time. Write, start and
// unused-operation items and ticks while off take 3 cycles from acceptance to
// the next acceptance; other ticks that read no table entry and do no ramp
// step take 4; a ramp step or a tick that fetches a marker takes 5; a tick
// that fetches a ramp point takes 39, set by the serial divider that forms
// the ramp step one bit per cycle. A stalled output adds the stalled cycles.
// The result sits in an output register, so the next transaction can be
// taken while a result still waits. Table entries read before being written
// give undefined results; there is no clearing pass after reset.
// depends on aeg_pkg, aeg_table and aeg_divider
`default_nettype none

module adsr_envelope_generator
  import aeg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire aeg_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output aeg_out_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_STEP = 3'd4;
  localparam logic [2:0] S_REQ  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]                 state_r, state_nxt;
  logic [3:0]                 phase_r, phase_nxt;
  logic signed [LEVEL_W-1:0]  level_r, level_nxt;
  logic [PTR_W-1:0]           ptr_r, ptr_nxt;
  logic signed [15:0]         cnt_r, cnt_nxt;
  logic [ACC_W-1:0]           step_r, step_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  aeg_in_t                    item_r, item_nxt;
  logic                       out_valid_r, out_valid_nxt;
  aeg_out_t                   out_data_r, out_data_nxt;

  logic signed [LEVEL_W-1:0]  init_level_r;
  logic signed [LEVEL_W-1:0]  sus_level_r;
  logic signed [LEVEL_W-1:0]  rel_rate_r;
  logic                       hang_mode_r;

  logic                       tbl_we;
  logic                       tbl_re;
  logic [PTR_W-1:0]           tbl_rptr;
  entry_t                     tbl_wentry;
  entry_t                     rd_entry;

  logic                       div_start;
  logic signed [ACC_W-1:0]    div_num;
  logic                       div_done;
  logic [ACC_W-1:0]           div_quo;

  logic signed [LEVEL_W-1:0]  lvl_dec;
  logic signed [LEVEL_W-1:0]  sus_div16;
  logic signed [15:0]         cnt_dec;
  logic [ACC_W-1:0]           acc_sum;
  logic [LEVEL_W-1:0]         diff16;
  logic                       wr_in_range;
  logic                       jump_in_range;

  assign tbl_wentry    = '{delay: item_r.entry_delay, value: item_r.entry_value};
  assign wr_in_range   = (32'(item_r.entry_index) < TABLE_DEPTH);
  assign jump_in_range = (32'($unsigned(rd_entry.value)) < TABLE_DEPTH);
  assign lvl_dec       = level_r - rel_rate_r;
  // signed divide by 16 rounding toward zero
  assign sus_div16     = sus_level_r[LEVEL_W-1] ? ((sus_level_r + 16'sd15) >>> 4)
                                                : (sus_level_r >>> 4);
  assign cnt_dec       = cnt_r - 16'sd1;
  assign acc_sum       = acc_r + step_r;
  assign diff16        = rd_entry.value - level_r;
  assign div_num       = {diff16, 16'h0};

  aeg_table u_table (
    .clk      (clk),
    .wr_en    (tbl_we),
    .wr_addr  (IDX_W'(item_r.entry_index)),
    .wr_entry (tbl_wentry),
    .rd_en    (tbl_re),
    .rd_ptr   (tbl_rptr),
    .rd_entry (rd_entry)
  );

  aeg_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (rd_entry.delay),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    level_nxt     = level_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    tbl_we        = 1'b0;
    tbl_re        = 1'b0;
    tbl_rptr      = ptr_r;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_OUT;
        case (item_r.operation)
          OP_WRITE: tbl_we = wr_in_range;
          OP_START: phase_nxt = PH_START;
          OP_TICK: begin
            if (phase_r != PH_OFF) begin
              state_nxt = S_REQ;
              case (phase_r) inside
                PH_START: begin
                  level_nxt = init_level_r;
                  if (hang_mode_r) begin
                    phase_nxt = PH_HANG;
                  end else begin
                    acc_nxt   = {init_level_r, 16'h0};
                    ptr_nxt   = '0;
                    phase_nxt = PH_FETCH;
                    tbl_re    = 1'b1;
                    tbl_rptr  = '0;
                    state_nxt = S_DEC;
                  end
                end
                PH_LOOP: begin
                  acc_nxt   = {level_r, 16'h0};
                  ptr_nxt   = '0;
                  phase_nxt = PH_FETCH;
                  tbl_re    = 1'b1;
                  tbl_rptr  = '0;
                  state_nxt = S_DEC;
                end
                PH_FETCH: begin
                  tbl_re    = 1'b1;
                  state_nxt = S_DEC;
                end
                PH_RAMP: state_nxt = S_STEP;
                PH_DECAY, PH_RELEASE: begin
                  level_nxt = lvl_dec;
                  if (sus_level_r != '0 && phase_r == PH_DECAY) begin
                    if (lvl_dec < sus_level_r) begin
                      level_nxt = sus_level_r;
                      cnt_nxt   = sus_div16;
                      phase_nxt = PH_SUSTAIN;
                    end
                  end else if (lvl_dec < 16'sd100) begin
                    level_nxt = '0;
                    phase_nxt = PH_OFF;
                  end
                end
                PH_SUSTAIN: begin
                  cnt_nxt = cnt_dec;
                  if (cnt_dec == 16'sd0) begin
                    phase_nxt = PH_RELEASE;
                  end
                end
                default: ;
              endcase
            end
          end
          default: ;
        endcase
      end

      S_DEC: begin
        cnt_nxt   = rd_entry.delay;
        state_nxt = S_REQ;
        case (rd_entry.delay)
          DLY_END:     phase_nxt = PH_OFF;
          DLY_HANG:    phase_nxt = PH_HANG;
          DLY_RESTART: phase_nxt = PH_START;
          DLY_JUMP: begin
            ptr_nxt = jump_in_range ? PTR_W'($unsigned(rd_entry.value))
                                    : PTR_W'(TABLE_DEPTH);
          end
          default: begin
            div_start = 1'b1;
            phase_nxt = PH_RAMP;
            if (32'(ptr_r) < TABLE_DEPTH) begin
              ptr_nxt = ptr_r + PTR_W'(1);
            end
            state_nxt = S_DIV;
          end
        endcase
      end

      S_DIV: begin
        if (div_done) begin
          step_nxt  = div_quo;
          state_nxt = S_STEP;
        end
      end

      S_STEP: begin
        acc_nxt   = acc_sum;
        level_nxt = acc_sum[ACC_W-1:ACC_W-LEVEL_W];
        cnt_nxt   = cnt_dec;
        if (cnt_dec <= 16'sd0) begin
          phase_nxt = PH_FETCH;
        end
        state_nxt = S_REQ;
      end

      S_REQ: begin
        // release wins over decay
        if (item_r.release_request) begin
          phase_nxt = PH_RELEASE;
        end else if (item_r.decay_request) begin
          phase_nxt = PH_DECAY;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{level: level_r, phase: phase_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_OFF;
      level_r     <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      level_r     <= level_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_level_r <= '0;
      sus_level_r  <= '0;
      rel_rate_r   <= '0;
      hang_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INITIAL: init_level_r <= cfg_wdata;
        REG_SUSTAIN: sus_level_r  <= cfg_wdata;
        REG_RELEASE: rel_rate_r   <= cfg_wdata;
        REG_HANG:    hang_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for adsr_envelope_generator: a directed table, then random
// envelope programs checked against a cycle-free predictor of level and phase
// depends on aeg_pkg and the adsr_envelope_generator rtl
`timescale 1ns / 100ps

module tb_top;
  import aeg_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic signed [15:0] RELEASE_FLOOR = 16'sd100;
  localparam int SUSTAIN_DIV = 16;
  localparam int ITEMS = 1250;
  localparam int PHASES = 6;
  localparam int DIR_ROWS = 25;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER = 330;

  typedef struct {
    aeg_in_t  item;
    bit       typed;
    aeg_out_t want;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  aeg_in_t          in_data;
  logic             out_valid;
  logic             out_stall;
  aeg_out_t         out_data;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  adsr_envelope_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [3:0]         env_phase;
  logic signed [15:0] env_level;
  logic signed [15:0] env_count;
  logic [31:0]        env_step;
  logic [31:0]        env_acc;
  int                 env_ptr;
  entry_t             pt_store [TABLE_DEPTH];
  bit                 pt_written [TABLE_DEPTH];
  logic signed [15:0] reg_initial_level;
  logic signed [15:0] reg_sustain_level;
  logic signed [15:0] reg_release_rate;
  logic               reg_hang_mode;

  aeg_out_t expected_levels [$];
  dir_row_t dir_rows [DIR_ROWS];
  int       err_count;
  int       result_count;
  int       live_items;
  int       tx_odds;
  int       rx_odds;
  bit       gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // one envelope tick, only called when the envelope is running
  function automatic void envelope_tick();
    entry_t ent;
    int     diff;
    int     num;
    int     sus;
    bit     fetch;
    bit     stepping;
    fetch = 1'b0;
    stepping = 1'b0;
    case (env_phase) inside
      PH_START: begin
        env_level = reg_initial_level;
        if (reg_hang_mode) begin
          env_phase = PH_HANG;
        end else begin
          env_ptr = 0;
          env_acc = {env_level, 16'h0000};
          env_phase = PH_FETCH;
          fetch = 1'b1;
        end
      end
      PH_LOOP: begin
        env_ptr = 0;
        env_acc = {env_level, 16'h0000};
        env_phase = PH_FETCH;
        fetch = 1'b1;
      end
      PH_FETCH: fetch = 1'b1;
      PH_RAMP: stepping = 1'b1;
      PH_DECAY, PH_RELEASE: begin
        env_level = env_level - reg_release_rate;
        if (reg_sustain_level != 0 && env_phase == PH_DECAY) begin
          if (env_level < reg_sustain_level) begin
            sus = reg_sustain_level;
            env_level = reg_sustain_level;
            env_count = 16'(sus / SUSTAIN_DIV);
            env_phase = PH_SUSTAIN;
          end
        end else if (env_level < RELEASE_FLOOR) begin
          env_level = '0;
          env_phase = PH_OFF;
        end
      end
      PH_SUSTAIN: begin
        env_count = env_count - 16'sd1;
        if (env_count == 0) env_phase = PH_RELEASE;
      end
      default: ;
    endcase
    if (fetch) begin
      ent = (env_ptr < TABLE_DEPTH) ? pt_store[env_ptr] : '0;
      env_count = ent.delay;
      case (ent.delay)
        DLY_END: env_phase = PH_OFF;
        DLY_HANG: env_phase = PH_HANG;
        DLY_JUMP: begin
          env_ptr = (int'($unsigned(ent.value)) < TABLE_DEPTH) ?
                    int'($unsigned(ent.value)) : TABLE_DEPTH;
        end
        DLY_RESTART: env_phase = PH_START;
        default: begin
          // (target - level) << 16 wraps at 32 bits, division truncates toward zero
          diff = int'(ent.value) - int'(env_level);
          num = diff << 16;
          env_step = num / int'(ent.delay);
          env_phase = PH_RAMP;
          if (env_ptr < TABLE_DEPTH) env_ptr++;
          stepping = 1'b1;
        end
      endcase
    end
    if (stepping) begin
      env_acc = env_acc + env_step;
      env_level = env_acc[31:16];
      env_count = env_count - 16'sd1;
      if (env_count <= 0) env_phase = PH_FETCH;
    end
  endfunction

  function automatic aeg_out_t envelope_step(input aeg_in_t it);
    aeg_out_t res;
    case (it.operation)
      OP_WRITE: begin
        pt_store[it.entry_index] = '{delay: it.entry_delay, value: it.entry_value};
        pt_written[it.entry_index] = 1'b1;
      end
      OP_START: env_phase = PH_START;
      OP_TICK: begin
        if (env_phase != PH_OFF) begin
          envelope_tick();
          if (it.decay_request) env_phase = PH_DECAY;
          if (it.release_request) env_phase = PH_RELEASE;
        end
      end
      default: ;
    endcase
    res.level = env_level;
    res.phase = env_phase;
    return res;
  endfunction

  // slot the next tick would read, or -1 when it reads none
  function automatic int next_fetch_slot();
    if ((env_phase == PH_START && !reg_hang_mode) || env_phase == PH_LOOP) return 0;
    if (env_phase == PH_FETCH && env_ptr < TABLE_DEPTH) return env_ptr;
    return -1;
  endfunction

  function automatic dir_row_t dir_row(input logic [1:0] op, input logic [4:0] slot,
                                       input logic signed [15:0] dly,
                                       input logic signed [15:0] val,
                                       input bit dec, input bit rel, input bit typed,
                                       input logic signed [15:0] lvl, input logic [3:0] ph);
    dir_row_t r;
    r.item = '{operation: op, entry_index: slot, entry_delay: dly, entry_value: val,
               decay_request: dec, release_request: rel};
    r.typed = typed;
    r.want = '{level: lvl, phase: ph};
    return r;
  endfunction

  function automatic aeg_in_t noise_item();
    aeg_in_t it;
    it.operation = 2'($urandom_range(0, 3));
    it.entry_index = 5'($urandom_range(0, TABLE_DEPTH - 1));
    it.entry_delay = 16'($urandom);
    it.entry_value = 16'($urandom);
    it.decay_request = 1'($urandom_range(0, 1));
    it.release_request = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // mostly short ramps, then markers, long and negative ramps now and then
  function automatic void pick_point(output logic signed [15:0] dly,
                                     output logic signed [15:0] val);
    int r;
    r = $urandom_range(0, 99);
    val = 16'($urandom);
    if (r < 50) dly = 16'($urandom_range(1, 8));
    else if (r < 58) dly = 16'($urandom_range(9, 40));
    else if (r < 60) dly = 16'($urandom_range(1000, 32767));
    else if (r < 67) dly = 16'(-int'($urandom_range(4, 32768)));
    else if (r < 76) dly = DLY_END;
    else if (r < 83) dly = DLY_HANG;
    else if (r < 93) begin
      dly = DLY_JUMP;
      if ($urandom_range(0, 7) != 0) val = 16'($urandom_range(0, TABLE_DEPTH - 1));
    end else dly = DLY_RESTART;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic send_item(input aeg_in_t it, input bit typed, input aeg_out_t typed_want);
    aeg_out_t pred;
    if (gaps_on && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = envelope_step(it);
    expected_levels.push_back(typed ? typed_want : pred);
  endtask

  // random transaction; an unwritten slot about to be fetched is written first
  task automatic offer(input aeg_in_t it);
    aeg_in_t fill;
    int      slot;
    slot = next_fetch_slot();
    if (it.operation == OP_TICK && slot >= 0 && !pt_written[slot]) begin
      fill = noise_item();
      fill.operation = OP_WRITE;
      fill.entry_index = 5'(slot);
      pick_point(fill.entry_delay, fill.entry_value);
      live_items++;
      send_item(fill, 1'b0, '0);
    end
    live_items++;
    send_item(it, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] lvl0, input logic [15:0] sus,
                                input logic [15:0] rate, input logic hang);
    put_reg(REG_INITIAL, lvl0);
    put_reg(REG_SUSTAIN, sus);
    put_reg(REG_RELEASE, rate);
    put_reg(REG_HANG, {15'd0, hang});
    cfg_we <= 1'b0;
    reg_initial_level = lvl0;
    reg_sustain_level = sus;
    reg_release_rate = rate;
    reg_hang_mode = hang;
  endtask

  // a short table program, a start, then a run of ticks with stray transactions
  task automatic run_episode();
    aeg_in_t it;
    int      n;
    int      base;
    int      ticks;
    case ($urandom_range(0, 2))
      0: tx_odds = 0;
      1: tx_odds = 3;
      default: tx_odds = 12;
    endcase
    n = $urandom_range(1, 5);
    base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TABLE_DEPTH - 1) : 0;
    for (int k = 0; k < n; k++) begin
      it = noise_item();
      it.operation = OP_WRITE;
      it.entry_index = 5'((base + k) % TABLE_DEPTH);
      pick_point(it.entry_delay, it.entry_value);
      offer(it);
    end
    it = noise_item();
    it.operation = OP_START;
    offer(it);
    ticks = $urandom_range(4, 40);
    for (int k = 0; k < ticks; k++) begin
      it = noise_item();
      if ($urandom_range(0, 11) != 0) begin
        it.operation = OP_TICK;
        it.decay_request = ($urandom_range(0, 14) == 0);
        it.release_request = ($urandom_range(0, 24) == 0);
      end
      offer(it);
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    aeg_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count <= result_count + 1;
      if (expected_levels.size() == 0) begin
        report_mismatch("result with nothing pending, level", out_data.level, 0);
      end else begin
        want = expected_levels.pop_front();
        if (out_data.level !== want.level)
          report_mismatch("level", out_data.level, want.level);
        if (out_data.phase !== want.phase)
          report_mismatch("phase", out_data.phase, want.phase);
      end
    end
  end

  // receiver side: random stall bursts and one long hold-off
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    rx_odds = 5;
    forever begin
      @(posedge clk);
      if (!held && result_count >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (gaps_on && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0: rx_odds = 0;
          1: rx_odds = 3;
          default: rx_odds = 10;
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [15:0] set_lvl [PHASES];
    logic [15:0] set_sus [PHASES];
    logic [15:0] set_rate [PHASES];
    bit          set_hang [PHASES];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_INITIAL;
    cfg_wdata = '0;
    live_items = 0;
    tx_odds = 4;
    gaps_on = 1'b1;
    env_phase = PH_OFF;
    env_level = '0;
    env_count = '0;
    env_step = '0;
    env_acc = '0;
    env_ptr = 0;
    reg_initial_level = '0;
    reg_sustain_level = '0;
    reg_release_rate = '0;
    reg_hang_mode = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pt_store[i] = '0;
      pt_written[i] = 1'b0;
    end

    // settings for the directed part: initial 1000, sustain 2500, rate 1200
    // requests are ignored while off; the all-ones row is the unused operation
    dir_rows[0]  = dir_row(OP_TICK, 0, 0, 0, 1, 1, 1, 0, PH_OFF);
    dir_rows[1]  = dir_row(OP_NONE, 31, -1, -1, 1, 1, 1, 0, PH_OFF);
    dir_rows[2]  = dir_row(OP_WRITE, 0, 4, 3000, 0, 0, 1, 0, PH_OFF);
    dir_rows[3]  = dir_row(OP_WRITE, 1, DLY_JUMP, 3, 0, 0, 1, 0, PH_OFF);
    dir_rows[4]  = dir_row(OP_WRITE, 3, DLY_HANG, 0, 0, 0, 1, 0, PH_OFF);
    dir_rows[5]  = dir_row(OP_WRITE, 31, 32767, 32767, 0, 0, 1, 0, PH_OFF);
    dir_rows[6]  = dir_row(OP_START, 0, 0, 0, 0, 0, 1, 0, PH_START);
    // ramp 1000 -> 3000 over four ticks, then jump to the hang marker
    dir_rows[7]  = dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, PH_OFF);
    dir_rows[8]  = dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, PH_OFF);
    dir_rows[9]  = dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, PH_OFF);
    dir_rows[10] = dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, PH_OFF);
    dir_rows[11] = dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, PH_OFF);
    dir_rows[12] = dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, PH_OFF);
    // decay into sustain, release, sit exactly on the floor, then drop to off
    dir_rows[13] = dir_row(OP_TICK, 0, 0, 0, 1, 0, 0, 0, PH_OFF);
    dir_rows[14] = dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, PH_OFF);
    dir_rows[15] = dir_row(OP_TICK, 0, 0, 0, 0, 1, 0, 0, PH_OFF);
    dir_rows[16] = dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, PH_OFF);
    dir_rows[17] = dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, PH_OFF);
    dir_rows[18] = dir_row(OP_TICK, 0, 0, 0, 0, 0, 1, 0, PH_OFF);
    // negative delay ramp with a wrapping step, restart marker, release beats decay
    dir_rows[19] = dir_row(OP_WRITE, 0, -5, -32768, 0, 0, 1, 0, PH_OFF);
    dir_rows[20] = dir_row(OP_WRITE, 1, DLY_RESTART, 0, 0, 0, 1, 0, PH_OFF);
    dir_rows[21] = dir_row(OP_START, 0, 0, 0, 0, 0, 1, 0, PH_START);
    dir_rows[22] = dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, PH_OFF);
    dir_rows[23] = dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, PH_OFF);
    dir_rows[24] = dir_row(OP_TICK, 0, 0, 0, 1, 1, 0, 0, PH_OFF);

    set_lvl  = '{16'd0, 16'h8000, 16'h7FFF, 16'($urandom), 16'h8000, 16'($urandom)};
    set_sus  = '{16'd2000, 16'd0, 16'h7FFF, 16'($urandom_range(16, 4000)), 16'h8000,
                 16'($urandom_range(0, 40) - 20)};
    set_rate = '{16'd150, 16'h7FFF, 16'h8000, 16'($urandom_range(1, 3000)), 16'd1,
                 16'($urandom)};
    set_hang = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'($urandom_range(0, 1))};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apply_settings(16'sd1000, 16'sd2500, 16'sd1200, 1'b0);
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      apply_settings(set_lvl[p], set_sus[p], set_rate[p], set_hang[p]);
      if (p == PHASES - 1) gaps_on = 1'b0;
      while (live_items < (p + 1) * ITEMS / PHASES) run_episode();
    end
    drain();
    repeat (60) @(posedge clk);

    if (err_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
